// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ksct_pkg.sv -----
// Package for the keyed stock count table: payload types, slot layout, status codes.
// No dependencies.
`timescale 1ns / 1ps

package ksct_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W       = 20;
    localparam int CNT_W       = 16;
    localparam int TOT_W       = 7;
    localparam int ST_W        = 3;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_USE = 1'b1;

    localparam logic [ST_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [ST_W-1:0] ST_CREATED   = 3'd1;
    localparam logic [ST_W-1:0] ST_USED      = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [ST_W-1:0] ST_SHORT     = 3'd4;
    localparam logic [ST_W-1:0] ST_MISSING   = 3'd5;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd6;
    localparam logic [ST_W-1:0] ST_SATURATED = 3'd7;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] part_key;
        logic [CNT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] remaining;
        logic [TOT_W-1:0] occupied;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } slot_t;

endpackage

// ----- hw/rtl/ksct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ksct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/keyed_stock_count_table_core.sv -----
// Top level of the keyed stock count table: control, scan and write-back.
// Depends on ksct_pkg, ksct_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   req channel: req_valid / req_stall / req (action, part_key, amount).
//   rsp channel: rsp_valid / rsp_stall / rsp (status, remaining, occupied).
//   One response per request, in order.
// Timing
//   Each request scans every slot of the table RAM through its one read port,
//   one slot per cycle, then passes a drain state and writes back at most once
//   in the commit state; a new request is taken only back in the idle state.
//   A new request is taken while the previous response still waits in the
//   output register.
// Reset
//   After rst_n releases, a clearing pass marks every slot free;
//   req_stall stays high meanwhile.
// Stall
//   While rsp_stall holds, the response stays put; a request already accepted
//   finishes its scan and waits before its write-back.
module keyed_stock_count_table_core
    import ksct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW     = $clog2(ENTRIES);
    localparam int SLOT_W = $bits(slot_t);
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             rd_pend_reg;
    logic [AW-1:0]    rd_idx_reg;
    req_t             req_reg;
    logic             hit_reg, free_reg;
    logic [AW-1:0]    hit_idx_reg, free_idx_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg, rsp_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_slot, rd_slot;
    logic [SLOT_W-1:0] rd_raw;

    logic          req_take, rsp_take, commit_go, scan_done;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] diff;

    assign req_take  = req_valid && !req_stall;
    assign rsp_take  = rsp_valid_reg && !rsp_stall;
    assign commit_go = (state_reg == S_COMMIT) && (!rsp_valid_reg || !rsp_stall);
    assign scan_done = (idx_reg == LAST_IDX);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_slot   = slot_t'(rd_raw);
    assign rd_en     = (state_reg == S_SCAN);

    assign sum  = {1'b0, hit_cnt_reg} + {1'b0, req_reg.amount};
    assign diff = hit_cnt_reg - req_reg.amount;

    ksct_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(ENTRIES)
    ) u_slots (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(SLOT_W'(wr_slot)),
        .rd_en  (rd_en),
        .rd_addr(idx_reg),
        .rd_data(rd_raw)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (scan_done)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (scan_done)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    // Write-back decision, clearing writes and response
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_slot    = '{valid: 1'b1, key: req_reg.part_key, count: hit_cnt_reg};
        total_next = total_reg;
        rsp_next   = '{status: ST_MISSING, remaining: '0, occupied: total_reg};
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_slot = '0;
        end
        else if (commit_go)
        begin
            if (req_reg.action == ACT_ADD)
            begin
                if (hit_reg)
                begin
                    wr_en = 1'b1;
                    if (sum[CNT_W])
                    begin
                        wr_slot.count      = '1;
                        rsp_next.status    = ST_SATURATED;
                        rsp_next.remaining = '1;
                    end
                    else
                    begin
                        wr_slot.count      = sum[CNT_W-1:0];
                        rsp_next.status    = ST_ADDED;
                        rsp_next.remaining = sum[CNT_W-1:0];
                    end
                end
                else if (free_reg)
                begin
                    wr_en              = 1'b1;
                    wr_addr            = free_idx_reg;
                    wr_slot.count      = req_reg.amount;
                    total_next         = total_reg + 1'b1;
                    rsp_next.status    = ST_CREATED;
                    rsp_next.remaining = req_reg.amount;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            else
            begin
                if (!hit_reg)
                begin
                    rsp_next.status = ST_MISSING;
                end
                else if (hit_cnt_reg >= req_reg.amount)
                begin
                    wr_en         = 1'b1;
                    wr_slot.count = diff;
                    if (diff == '0)
                    begin
                        wr_slot.valid   = 1'b0;
                        total_next      = total_reg - 1'b1;
                        rsp_next.status = ST_REMOVED;
                    end
                    else
                    begin
                        rsp_next.status    = ST_USED;
                        rsp_next.remaining = diff;
                    end
                end
                else
                begin
                    rsp_next.status    = ST_SHORT;
                    rsp_next.remaining = hit_cnt_reg;
                end
            end
            rsp_next.occupied = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_en;
            total_reg   <= total_next;
            if (req_take)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (rd_pend_reg)
            begin
                if (rd_slot.valid && (rd_slot.key == req_reg.part_key) && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!rd_slot.valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (commit_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (req_take)
        begin
            req_reg <= req;
        end
        if (rd_pend_reg)
        begin
            if (rd_slot.valid && (rd_slot.key == req_reg.part_key) && !hit_reg)
            begin
                hit_idx_reg <= rd_idx_reg;
                hit_cnt_reg <= rd_slot.count;
            end
            if (!rd_slot.valid && !free_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (commit_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `ASSERT_NOW(a_total_bound, 1'b1, (ENTRIES > 127) || (total_reg <= TOT_W'(ENTRIES)),
        "valid slot count exceeds table size")
    `ASSERT_NEXT(a_create_counts, commit_go && (req_reg.action == ACT_ADD) && !hit_reg && free_reg,
        (total_reg == $past(total_reg) + 1'b1) && rsp_valid_reg,
        "slot creation did not bump the count")
    `ASSERT_NOW(a_absent_zero,
        rsp_valid_reg && (rsp_reg.status == ST_REMOVED || rsp_reg.status == ST_MISSING
            || rsp_reg.status == ST_FULL),
        rsp_reg.remaining == '0, "absent key reports nonzero stock")
    `ASSERT_NOW(a_no_write_in_scan, (state_reg == S_SCAN) || (state_reg == S_DRAIN),
        !wr_en, "table write during scan")

endmodule
